// File: hw/rtl/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

  // Width that holds any word length or store index up to 32 entries.
  localparam int unsigned LEN_W = 5;

  // Terminal characters that steer the framing.
  localparam logic [7:0] CH_START = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Write port of one character store.
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // A closed frame handed from the parser to the emitter.
  typedef struct packed {
    logic             valid;
    logic             withp;
    logic [LEN_W-1:0] clen;
    logic [LEN_W-1:0] plen;
  } frame_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcf_store.sv
`default_nettype none

module tcf_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcf_ctrl.sv
`default_nettype none

module tcf_ctrl
  import tcf_pkg::*;
#(
  parameter int unsigned CMD_LEN   = 16,
  parameter int unsigned PARAM_LEN = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output store_wr_t       cmd_wr,
  output store_wr_t       par_wr,
  output frame_t          frame
);

  typedef enum logic [3:0] {
    P_SEARCH = 4'b0001,
    P_CMD    = 4'b0010,
    P_SKIP   = 4'b0100,
    P_PARAM  = 4'b1000
  } phase_t;

  localparam logic [LEN_W-1:0] CMD_MAX = LEN_W'(CMD_LEN - 1);
  localparam logic [LEN_W-1:0] PAR_MAX = LEN_W'(PARAM_LEN - 1);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] wi_r, wi_nxt;
  logic [LEN_W-1:0] clen_r, clen_nxt;
  logic             is_eol, is_start, is_space;

  assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_start = (rx_byte == CH_START);
  assign is_space = (rx_byte == CH_SPACE);

  // Parser: decides store writes and frame closure for each accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    wi_nxt    = wi_r;
    clen_nxt  = clen_r;
    cmd_wr    = '{en: 1'b0, addr: wi_r, data: rx_byte};
    par_wr    = '{en: 1'b0, addr: wi_r, data: rx_byte};
    frame     = '{valid: 1'b0, withp: 1'b0, clen: clen_r, plen: '0};
    if (accept) begin
      case (phase_r)
        P_SEARCH: begin
          if (is_start) begin
            phase_nxt = P_CMD;
            wi_nxt    = '0;
          end
        end
        P_CMD: begin
          if (is_space) begin
            clen_nxt  = wi_r;
            phase_nxt = P_SKIP;
          end else if (is_eol || is_start) begin
            clen_nxt    = wi_r;
            frame.valid = 1'b1;
            frame.clen  = wi_r;
            phase_nxt   = is_eol ? P_SEARCH : P_CMD;
            wi_nxt      = '0;
          end else if (wi_r < CMD_MAX) begin
            cmd_wr.en = 1'b1;
            wi_nxt    = wi_r + 1'b1;
          end
        end
        P_SKIP: begin
          if (is_eol || is_start) begin
            frame.valid = 1'b1;
            phase_nxt   = is_eol ? P_SEARCH : P_CMD;
            wi_nxt      = '0;
          end else if (!is_space) begin
            par_wr.en   = 1'b1;
            par_wr.addr = '0;
            wi_nxt      = LEN_W'(1);
            phase_nxt   = P_PARAM;
          end
        end
        P_PARAM: begin
          if (is_space || is_eol || is_start) begin
            frame.valid = 1'b1;
            frame.withp = 1'b1;
            frame.plen  = wi_r;
            phase_nxt   = is_start ? P_CMD : P_SEARCH;
            wi_nxt      = '0;
          end else if (wi_r < PAR_MAX) begin
            par_wr.en = 1'b1;
            wi_nxt    = wi_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = P_SEARCH;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_SEARCH;
      wi_r    <= '0;
      clen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      wi_r    <= wi_nxt;
      clen_r  <= clen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcf_emit.sv
`default_nettype none

module tcf_emit
  import tcf_pkg::*;
#(
  parameter int unsigned CW = 4,
  parameter int unsigned PW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire frame_t        frame,
  output logic               busy,
  output logic               rd_en,
  output logic [CW-1:0]      cmd_raddr,
  output logic [PW-1:0]      par_raddr,
  input  wire logic [7:0]    cmd_rdata,
  input  wire logic [7:0]    par_rdata,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_part,
  output logic [7:0]         out_char_code,
  output logic               out_empty_res,
  output logic               out_with_parameter,
  output logic               out_last
);

  localparam int unsigned IW = (CW > PW) ? CW : PW;

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_FETCH = 3'b010,
    E_SHOW  = 3'b100
  } emit_state_t;

  emit_state_t   state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] clen_r, clen_nxt;
  logic [IW-1:0] plen_r, plen_nxt;
  logic          part_r, part_nxt;
  logic          empty_r, empty_nxt;
  logic          withp_r, withp_nxt;
  logic          cmd_end, par_end;

  assign cmd_end = ({1'b0, idx_r} + 1'b1) == {1'b0, clen_r};
  assign par_end = ({1'b0, idx_r} + 1'b1) == {1'b0, plen_r};

  // Item fields come straight from the registered read data and the
  // sequencer registers.
  assign busy               = (state_r != E_IDLE);
  assign rd_en              = (state_r == E_FETCH);
  assign cmd_raddr          = idx_r[CW-1:0];
  assign par_raddr          = idx_r[PW-1:0];
  assign out_valid          = (state_r == E_SHOW);
  assign out_part           = part_r;
  assign out_empty_res      = empty_r;
  assign out_with_parameter = withp_r;
  assign out_char_code      = empty_r ? 8'h00 : (part_r ? par_rdata : cmd_rdata);
  assign out_last           = part_r ? par_end
                                     : ((empty_r || cmd_end) && (plen_r == '0));

  // Sequencer: one read then one output transfer per character.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    clen_nxt  = clen_r;
    plen_nxt  = plen_r;
    part_nxt  = part_r;
    empty_nxt = empty_r;
    withp_nxt = withp_r;
    case (state_r)
      E_IDLE: begin
        if (frame.valid) begin
          clen_nxt  = IW'(frame.clen);
          plen_nxt  = frame.withp ? IW'(frame.plen) : '0;
          withp_nxt = frame.withp;
          idx_nxt   = '0;
          part_nxt  = 1'b0;
          empty_nxt = (frame.clen == '0);
          state_nxt = (frame.clen == '0) ? E_SHOW : E_FETCH;
        end
      end
      E_FETCH: begin
        state_nxt = E_SHOW;
      end
      E_SHOW: begin
        if (out_ready) begin
          if (!part_r && !empty_r && !cmd_end) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = E_FETCH;
          end else if (!part_r && (plen_r != '0)) begin
            part_nxt  = 1'b1;
            empty_nxt = 1'b0;
            idx_nxt   = '0;
            state_nxt = E_FETCH;
          end else if (part_r && !par_end) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = E_FETCH;
          end else begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    clen_r  <= clen_nxt;
    plen_r  <= plen_nxt;
    part_r  <= part_nxt;
    empty_r <= empty_nxt;
    withp_r <= withp_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/terminal_command_framer.sv
// After the closing byte the emitter reads the stores, then offers the first item; an empty
// command item is offered without a read. Each further item needs a store read, then an
// output transfer, plus any output stall. A closing byte holds the input off until the N
// items of its frame are transferred, with N up to CMD_LEN+PARAM_LEN-2; other bytes do not.
// Reset (rst_n, synchronous, active low) returns to searching for '>' with the stores left
// as they are; both are read at each fetch, but only entries written in this frame are shown.
`default_nettype none

module terminal_command_framer
  import tcf_pkg::*;
#(
  parameter int unsigned CMD_LEN   = 16,
  parameter int unsigned PARAM_LEN = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_part,
  output logic [7:0]      out_char_code,
  output logic            out_empty_res,
  output logic            out_with_parameter,
  output logic            out_last
);

  localparam int unsigned CW = $clog2(CMD_LEN);
  localparam int unsigned PW = $clog2(PARAM_LEN);

  store_wr_t     cmd_wr, par_wr;
  frame_t        frame;
  logic          busy, rd_en, accept;
  logic [CW-1:0] cmd_raddr;
  logic [PW-1:0] par_raddr;
  logic [7:0]    cmd_rdata, par_rdata;

  // Bytes are taken only while no frame is being emitted.
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  tcf_ctrl #(
    .CMD_LEN   (CMD_LEN),
    .PARAM_LEN (PARAM_LEN)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cmd_wr  (cmd_wr),
    .par_wr  (par_wr),
    .frame   (frame)
  );

  tcf_store #(
    .DEPTH (CMD_LEN),
    .AW    (CW)
  ) u_cmd_store (
    .clk     (clk),
    .we      (cmd_wr.en),
    .waddr   (cmd_wr.addr[CW-1:0]),
    .wdata   (cmd_wr.data),
    .re      (rd_en),
    .raddr   (cmd_raddr),
    .rdata_r (cmd_rdata)
  );

  tcf_store #(
    .DEPTH (PARAM_LEN),
    .AW    (PW)
  ) u_par_store (
    .clk     (clk),
    .we      (par_wr.en),
    .waddr   (par_wr.addr[PW-1:0]),
    .wdata   (par_wr.data),
    .re      (rd_en),
    .raddr   (par_raddr),
    .rdata_r (par_rdata)
  );

  tcf_emit #(
    .CW (CW),
    .PW (PW)
  ) u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame              (frame),
    .busy               (busy),
    .rd_en              (rd_en),
    .cmd_raddr          (cmd_raddr),
    .par_raddr          (par_raddr),
    .cmd_rdata          (cmd_rdata),
    .par_rdata          (par_rdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_part           (out_part),
    .out_char_code      (out_char_code),
    .out_empty_res      (out_empty_res),
    .out_with_parameter (out_with_parameter),
    .out_last           (out_last)
  );

  // No byte is taken while an item is on offer.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while an item is on offer");

  // A frame closes only when the emitter can take it.
  a_frame_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame.valid |-> !busy)
    else $error("frame closed while emitter busy");

  // The emitter goes quiet after the final item of a frame.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("item offered after final transfer of frame");

  // An empty command item carries no character and belongs to the command.
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (!out_part && (out_char_code == 8'h00)))
    else $error("malformed empty command item");

  // Store writes only happen on a byte transfer.
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_wr.en || par_wr.en) |-> accept)
    else $error("store written without a byte transfer");

endmodule

`default_nettype wire
